/* design/rcst_pkg.sv */
// Shared constants, codes and lane structs for the RC reflectance sensor timer.
// No dependencies; every other design file imports this package.
`default_nettype none

package rcst_pkg;

   localparam int CHANNELS   = 5;
   localparam int CHAN_BITS  = 3;
   localparam int COUNT_BITS = 16;
   localparam int PIN_BITS   = 5;
   localparam int CSR_ABITS  = 3;
   localparam int CSR_DBITS  = 32;

   localparam logic [CHAN_BITS-1:0]  LAST_CHAN = CHAN_BITS'(CHANNELS - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [15:0] DARK_THRESHOLD_RESET = 16'h0600;
   localparam logic [15:0] TIMEOUT_COUNT_RESET  = 16'h0B00;

   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // register index, taken from paddr[2]
   localparam logic REG_DARK_THRESHOLD = 1'b0;
   localparam logic REG_TIMEOUT_COUNT  = 1'b1;

   typedef struct packed {
      logic                  start;
      logic                  tick;
      logic                  timeout_hit;
      logic [COUNT_BITS-1:0] count;
   } lane_ctrl_type;

   typedef struct packed {
      logic                  settled;
      logic                  dark;
      logic [COUNT_BITS-1:0] dtime;
   } lane_result_type;

endpackage

`default_nettype wire

/* design/rcst_if.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on rcst_pkg for field widths.
`default_nettype none

interface rcst_req_if;
   import rcst_pkg::*;
   logic                valid;
   logic                ready;
   logic                op;
   logic [PIN_BITS-1:0] pins;

   modport source (output valid, output op, output pins, input ready);
   modport sink   (input valid, input op, input pins, output ready);
endinterface

interface rcst_rsp_if;
   import rcst_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CHAN_BITS-1:0]  channel;
   logic [COUNT_BITS-1:0] discharge_time;
   logic                  dark;
   logic                  last;

   modport source (output valid, output channel, output discharge_time, output dark,
                   output last, input ready);
   modport sink   (input valid, input channel, input discharge_time, input dark,
                   input last, output ready);
endinterface

`default_nettype wire

/* design/rcst_lane.sv */
// One sensor channel: edge detect, capture of the discharge count and dark flag.
// Depends on rcst_pkg.
`default_nettype none

module rcst_lane (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rcst_pkg::lane_ctrl_type     ctrl,
   input  wire logic                        pin,
   input  wire logic [15:0]                 threshold,
   input  wire logic [15:0]                 timeout,
   output rcst_pkg::lane_result_type        res_next
);
   import rcst_pkg::*;

   logic                  prev_ff, prev_in;
   logic                  settled_ff, settled_in;
   logic                  dark_ff, dark_in;
   logic [COUNT_BITS-1:0] time_ff, time_in;
   logic                  capture;

   assign capture = ctrl.tick && (prev_ff != pin) && !settled_ff;

   always_comb begin
      prev_in    = prev_ff;
      settled_in = settled_ff;
      dark_in    = dark_ff;
      time_in    = time_ff;
      priority if (ctrl.start) begin
         prev_in    = 1'b1;
         settled_in = 1'b0;
         dark_in    = 1'b0;
         time_in    = '0;
      end else if (ctrl.tick) begin
         prev_in = pin;
         // pin change wins over a timeout on the same tick
         if (capture) begin
            settled_in = 1'b1;
            time_in    = ctrl.count;
            dark_in    = ctrl.count > threshold;
         end else if (ctrl.timeout_hit && !settled_ff) begin
            settled_in = 1'b1;
            time_in    = timeout;
            dark_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= 1'b1;
         settled_ff <= 1'b1;
         dark_ff    <= 1'b0;
         time_ff    <= '0;
      end else begin
         prev_ff    <= prev_in;
         settled_ff <= settled_in;
         dark_ff    <= dark_in;
         time_ff    <= time_in;
      end
   end

   assign res_next.settled = settled_in;
   assign res_next.dark    = dark_in;
   assign res_next.dtime   = time_in;

endmodule

`default_nettype wire

/* design/rcst_merge.sv */
// Snapshot of all lanes at the end of a measurement, drained one word per channel.
// Depends on rcst_pkg and rcst_rsp_if.
`default_nettype none

module rcst_merge (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       load,
   input  wire rcst_pkg::lane_result_type [rcst_pkg::CHANNELS-1:0] res,
   output logic                                            hold_busy,
   rcst_rsp_if.source                                      rsp_bus
);
   import rcst_pkg::*;

   logic                  hold_valid_ff, hold_valid_in;
   logic [CHAN_BITS-1:0]  idx_ff, idx_in;
   logic [COUNT_BITS-1:0] times_ff [CHANNELS];
   logic [CHANNELS-1:0]   dark_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAN_BITS-1:0]  chan_ff;
   logic [COUNT_BITS-1:0] dtime_ff;
   logic                  rdark_ff;
   logic                  last_ff;
   logic                  advance;

   // output register free or being taken
   assign advance = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = hold_valid_ff;
         if (hold_valid_ff) begin
            if (idx_ff == LAST_CHAN) begin
               hold_valid_in = 1'b0;
               idx_in        = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
      end
      if (load) begin
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < CHANNELS; i++) begin
            times_ff[i] <= res[i].dtime;
            dark_ff[i]  <= res[i].dark;
         end
      end
      if (advance && hold_valid_ff) begin
         chan_ff  <= idx_ff;
         dtime_ff <= times_ff[idx_ff];
         rdark_ff <= dark_ff[idx_ff];
         last_ff  <= (idx_ff == LAST_CHAN);
      end
   end

   assign hold_busy              = hold_valid_ff;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.channel        = chan_ff;
   assign rsp_bus.discharge_time = dtime_ff;
   assign rsp_bus.dark           = rdark_ff;
   assign rsp_bus.last           = last_ff;

   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      load |-> !hold_valid_ff)
      else $error("snapshot loaded while previous one still draining");

   a_last_is_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_ff) |-> (chan_ff == LAST_CHAN))
      else $error("last flag on wrong channel");

   a_drain_from_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(hold_valid_ff) |-> (idx_ff == '0))
      else $error("drain did not start at channel zero");

endmodule

`default_nettype wire

/* design/rc_reflectance_sensor_timer_unit.sv */
// Top level: elapsed counter, register file, five sensor lanes and result merge.
// Depends on rcst_pkg, rcst_if, rcst_lane and rcst_merge.
`default_nettype none

// Five RC reflectance channels are timed side by side, one lane each. A start
// word (op 0) clears the lanes and the counter; tick words are op 1, and one
// word is accepted each clock while req ready is high. When the last channel
// settles, the five results are copied into a snapshot and drained one per
// cycle while rsp ready is high. req ready drops only when a new measurement is
// running while the previous snapshot is still draining. Registers:
// 0x0 dark_threshold, 0x4 timeout_count, written through the APB-style port.
module rc_reflectance_sensor_timer_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   rcst_req_if.sink                             req_bus,
   rcst_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [rcst_pkg::CSR_ABITS-1:0]  csr_paddr,
   input  wire logic [rcst_pkg::CSR_DBITS-1:0]  csr_pwdata,
   output logic      [rcst_pkg::CSR_DBITS-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import rcst_pkg::*;

   logic [15:0]           threshold_ff, threshold_in;
   logic [15:0]           timeout_ff, timeout_in;
   logic [COUNT_BITS-1:0] elapsed_ff, elapsed_in;
   logic                  measuring_ff, measuring_in;

   logic                  accept, start, tick, finish, hold_busy, csr_write;
   logic [COUNT_BITS-1:0] count_inc;
   logic [CHANNELS-1:0]   settled_vec;
   lane_ctrl_type         ctrl;
   lane_result_type [CHANNELS-1:0] res;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      threshold_in = threshold_ff;
      timeout_in   = timeout_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_DARK_THRESHOLD: threshold_in = csr_pwdata[15:0];
            REG_TIMEOUT_COUNT:  timeout_in   = csr_pwdata[15:0];
            default:            threshold_in = threshold_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_DARK_THRESHOLD: csr_prdata = {16'h0000, threshold_ff};
         REG_TIMEOUT_COUNT:  csr_prdata = {16'h0000, timeout_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // a finishing tick needs measuring, so the snapshot is free whenever it loads
   assign req_bus.ready = !hold_busy || !measuring_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign start         = accept && (req_bus.op == OP_START);
   assign tick          = accept && (req_bus.op == OP_TICK) && measuring_ff;

   assign count_inc = (elapsed_ff == COUNT_MAX) ? elapsed_ff : elapsed_ff + 1'b1;

   assign ctrl.start       = start;
   assign ctrl.tick        = tick;
   assign ctrl.count       = count_inc;
   assign ctrl.timeout_hit = count_inc >= timeout_ff;

   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      rcst_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .pin       (req_bus.pins[g]),
         .threshold (threshold_ff),
         .timeout   (timeout_ff),
         .res_next  (res[g])
      );
      assign settled_vec[g] = res[g].settled;
   end

   assign finish = tick && (&settled_vec);

   always_comb begin
      elapsed_in   = elapsed_ff;
      measuring_in = measuring_ff;
      priority if (start) begin
         elapsed_in   = '0;
         measuring_in = 1'b1;
      end else if (tick) begin
         elapsed_in = count_inc;
         if (finish) begin
            measuring_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= DARK_THRESHOLD_RESET;
         timeout_ff   <= TIMEOUT_COUNT_RESET;
         elapsed_ff   <= '0;
         measuring_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         timeout_ff   <= timeout_in;
         elapsed_ff   <= elapsed_in;
         measuring_ff <= measuring_in;
      end
   end

   rcst_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (finish),
      .res       (res),
      .hold_busy (hold_busy),
      .rsp_bus   (rsp_bus)
   );

   a_finish_ends_run: assert property (@(posedge clock) disable iff (reset)
      finish |=> !measuring_ff)
      else $error("measurement still running after finish");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      start |=> (elapsed_ff == '0) && measuring_ff)
      else $error("start did not clear counter");

   a_idle_tick_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && !measuring_ff && (req_bus.op == OP_TICK)) |=> $stable(elapsed_ff))
      else $error("idle tick changed the counter");

endmodule

`default_nettype wire
